/* src/swm_pkg.sv */
`timescale 1ns / 1ps
// swm_pkg: shared control type for the sliding window median filter.
// No dependencies.
package swm_pkg;

    typedef struct packed {
        logic vld;
        logic le;
    } ctl_t;

endpackage

/* src/swm_cell.sv */
`timescale 1ns / 1ps
// swm_cell: one slot of the sorted window; holds a sample, its age and a valid bit.
// Depends on swm_pkg (ctl_t).
module swm_cell #(
    parameter int WINDOW      = 9,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic signed [SAMPLE_BITS-1:0]        x,
    input  logic signed [SAMPLE_BITS-1:0]        lo_val,
    input  logic [$clog2(WINDOW)-1:0]            lo_age,
    input  swm_pkg::ctl_t                        lo_ctl,
    input  logic signed [SAMPLE_BITS-1:0]        hi_val,
    input  logic [$clog2(WINDOW)-1:0]            hi_age,
    input  swm_pkg::ctl_t                        hi_ctl,
    input  logic                                 rb_in,
    output logic                                 rb_out,
    output logic                                 drop,
    output logic signed [SAMPLE_BITS-1:0]        val,
    output logic [$clog2(WINDOW)-1:0]            age,
    output swm_pkg::ctl_t                        ctl
);

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] AGE_MAX = AW'(WINDOW - 1);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [AW-1:0]                 age_reg, age_next;
    logic                          vld_reg, vld_next;

    logic signed [SAMPLE_BITS-1:0] o_val, p_val;
    logic [AW-1:0]                 o_age, p_age;
    logic                          o_vld, p_vld, o_le, p_le, le;

    assign le     = vld_reg && (val_reg <= x);
    assign drop   = vld_reg && (age_reg == AGE_MAX);
    assign rb_out = rb_in | drop;

    assign val = val_reg;
    assign age = age_reg;
    assign ctl = '{vld: vld_reg, le: le};

    // window after removing the oldest entry, at this slot and the one below
    assign o_val = rb_out ? hi_val     : val_reg;
    assign o_age = rb_out ? hi_age     : age_reg;
    assign o_vld = rb_out ? hi_ctl.vld : vld_reg;
    assign o_le  = rb_out ? hi_ctl.le  : le;
    assign p_val = rb_in  ? val_reg    : lo_val;
    assign p_age = rb_in  ? age_reg    : lo_age;
    assign p_vld = rb_in  ? vld_reg    : lo_ctl.vld;
    assign p_le  = rb_in  ? le         : lo_ctl.le;

    always_comb
    begin
        priority if (o_le)
        begin
            val_next = o_val;
            age_next = o_age + AW'(1);
            vld_next = o_vld;
        end
        else if (p_le)
        begin
            val_next = x;
            age_next = '0;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = p_val;
            age_next = p_age + AW'(1);
            vld_next = p_vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

/* src/sliding_window_median.sv */
`timescale 1ns / 1ps
// sliding_window_median: running median over the last WINDOW samples.
// Cell row, then median register; 1 transaction per cycle unless result_ready stalls.
// The sorted cell row takes the new sample and drops the oldest in the same update.
// Reset empties the row and the fill count; the first WINDOW-1 results carry ready_res 0.
// Depends on swm_pkg and swm_cell.
module sliding_window_median #(
    parameter int WINDOW      = 9,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS-1:0] median,
    output logic                          ready_res
);

    localparam int AW  = $clog2(WINDOW);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int MID = WINDOW / 2;
    localparam logic [CW-1:0] FULL = CW'(WINDOW);

    logic signed [SAMPLE_BITS-1:0] cval [WINDOW+1];
    logic [AW-1:0]                 cage [WINDOW+1];
    swm_pkg::ctl_t                 cctl [WINDOW+1];
    logic [WINDOW:0]               rb;
    logic [WINDOW-1:0]             drop_vec;
    logic [WINDOW-1:0]             vld_vec;

    logic          accept, load_out;
    logic          pend_reg, pend_next;
    logic          pend_full_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    logic          ready_res_reg;

    assign accept       = sample_valid && sample_ready;
    assign load_out     = pend_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !pend_reg || load_out;

    assign rb[0]           = 1'b0;
    assign cval[WINDOW]    = '0;
    assign cage[WINDOW]    = '0;
    assign cctl[WINDOW]    = '{vld: 1'b0, le: 1'b0};

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] lo_val;
            logic [AW-1:0]                 lo_age;
            swm_pkg::ctl_t                 lo_ctl;
            if (i == 0)
            begin : g_bot
                assign lo_val = '0;
                assign lo_age = '0;
                assign lo_ctl = '{vld: 1'b0, le: 1'b1};
            end
            else
            begin : g_mid
                assign lo_val = cval[i-1];
                assign lo_age = cage[i-1];
                assign lo_ctl = cctl[i-1];
            end

            swm_cell #(
                .WINDOW      (WINDOW),
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .load   (accept),
                .x      (sample),
                .lo_val (lo_val),
                .lo_age (lo_age),
                .lo_ctl (lo_ctl),
                .hi_val (cval[i+1]),
                .hi_age (cage[i+1]),
                .hi_ctl (cctl[i+1]),
                .rb_in  (rb[i]),
                .rb_out (rb[i+1]),
                .drop   (drop_vec[i]),
                .val    (cval[i]),
                .age    (cage[i]),
                .ctl    (cctl[i])
            );
            assign vld_vec[i] = cctl[i].vld;
        end
    endgenerate

    assign count_next = (count_reg == FULL) ? count_reg : count_reg + CW'(1);

    always_comb
    begin
        priority if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            pend_full_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (accept)
            begin
                count_reg     <= count_next;
                pend_full_reg <= (count_next == FULL);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg    <= pend_full_reg ? cval[MID] : '0;
            ready_res_reg <= pend_full_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign median       = median_reg;
    assign ready_res    = ready_res_reg;

    a_one_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(drop_vec))
        else $error("more than one oldest entry in the window");

    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) == int'(count_reg))
        else $error("valid cells disagree with fill count");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ready_res) |-> (count_reg == FULL))
        else $error("ready result before window filled");

    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !ready_res) |-> (median == '0))
        else $error("nonzero median while filling");

endmodule
